FILE: rtl/bpc32_pkg.sv
// Package for the 32-bit bit-permutation cipher: key layout, reset key and
// the permutation functions. Used by bit_permutation_cipher_32_unit.
// No dependencies.
`default_nettype none

package bpc32_pkg;

    localparam int BLOCK_BITS   = 32;
    localparam int KEY_REGS     = 8;
    localparam int ENTRIES_PER  = 4;
    localparam int ENTRY_BITS   = 5;
    localparam int KEY_REG_BITS = ENTRIES_PER * ENTRY_BITS;
    localparam int KEY_IDX_BITS = 3;
    localparam logic [7:0] PAD_BYTE = 8'h20;

    // Function select carried on tuser.
    localparam logic FUNC_ENCRYPT = 1'b0;
    localparam logic FUNC_DECRYPT = 1'b1;

    typedef logic [KEY_REG_BITS-1:0] key_reg_t;
    typedef logic [ENTRY_BITS-1:0]   key_entry_t;
    typedef key_entry_t [BLOCK_BITS-1:0] key_t;
    typedef logic [BLOCK_BITS-1:0]   word_t;

    // Default key after reset.
    localparam key_reg_t KEY_RESET [KEY_REGS] = '{
        20'd116646, 20'd7610, 20'd635368, 20'd553141,
        20'd67351, 20'd360409, 20'd617929, 20'd666774
    };

    // Encrypt: result bit (31-p) takes word bit key[p].
    function automatic word_t encrypt_word(input word_t w, input key_t key);
        word_t r;
        r = '0;
        for (int p = 0; p < BLOCK_BITS; p++) begin
            r[BLOCK_BITS-1-p] = w[key[p]];
        end
        return r;
    endfunction

    // Decrypt: result bit q takes word bit (31-k) for the lowest k whose
    // entry names q. A position that no entry names stays 0.
    function automatic word_t decrypt_word(input word_t w, input key_t key);
        word_t r;
        logic  found;
        r = '0;
        for (int q = 0; q < BLOCK_BITS; q++) begin
            found = 1'b0;
            for (int k = 0; k < BLOCK_BITS; k++) begin
                if (!found && (key[k] == ENTRY_BITS'(q))) begin
                    r[q]  = w[BLOCK_BITS-1-k];
                    found = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bit_permutation_cipher_32_unit.sv
// Top level of the 32-bit bit-permutation cipher: byte gathering, group
// word register, permutation and output byte serialiser.
// Depends on bpc32_pkg.
`default_nettype none

// The unit takes one byte beat per cycle and gathers four beats, first
// byte most significant, into a 32-bit word; a beat with tlast set closes
// a short group, which is padded with spaces (0x20). The tuser bit of the
// beat that closes a group selects encrypt (0) or decrypt (1). Each group
// gives four output beats, most significant byte first, tlast on the
// fourth. The closed word waits in a group register and is permuted on
// its way into the output serialiser register. The serialiser sends
// one byte per cycle while m_tready is high, so full groups flow at one
// byte per cycle; a group closed early by tlast is still sent as four
// output beats, and the input stalls only while a closed group waits
// for the serialiser. The key is eight 20-bit registers of four 5-bit
// entries each, written through the configuration port. The user must
// write it only while the unit is idle; the block does not enforce it.

module bit_permutation_cipher_32_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [19:0] cfg_wdata,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // last_byte
    input  wire logic        s_tuser,   // [0] func
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast    // out_last
);

    // Key registers and flattened key entries.
    bpc32_pkg::key_reg_t key_reg [bpc32_pkg::KEY_REGS];
    bpc32_pkg::key_t     key_ent;

    // Gathering state.
    logic [23:0] held_bytes_reg;
    logic [1:0]  held_count_reg;

    // Closed group waiting for the serialiser.
    logic                 grp_valid_reg;
    logic                 grp_func_reg;
    bpc32_pkg::word_t     grp_word_reg;

    // Output serialiser.
    logic                 out_valid_reg;
    logic [1:0]           out_idx_reg;
    bpc32_pkg::word_t     out_word_reg;

    logic                 in_beat;
    logic                 out_beat;
    logic                 grp_close;
    logic                 load;
    bpc32_pkg::word_t     closed_word;
    bpc32_pkg::word_t     perm_word;

    // Key writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < bpc32_pkg::KEY_REGS; i++) begin
                key_reg[i] <= bpc32_pkg::KEY_RESET[i];
            end
        end else if (cfg_we) begin
            key_reg[cfg_index] <= cfg_wdata;
        end
    end

    // Split the key registers into their 5-bit entries.
    always_comb begin
        for (int r = 0; r < bpc32_pkg::KEY_REGS; r++) begin
            for (int e = 0; e < bpc32_pkg::ENTRIES_PER; e++) begin
                key_ent[r*bpc32_pkg::ENTRIES_PER + e] =
                    key_reg[r][e*bpc32_pkg::ENTRY_BITS +: bpc32_pkg::ENTRY_BITS];
            end
        end
    end

    // Handshake decisions.
    assign out_beat  = out_valid_reg && m_tready;
    assign load      = grp_valid_reg && (!out_valid_reg || (out_beat && (out_idx_reg == 2'd3)));
    assign s_tready  = !grp_valid_reg || load;
    assign in_beat   = s_tvalid && s_tready;
    assign grp_close = in_beat && ((held_count_reg == 2'd3) || s_tlast);

    // Assemble the closed word, padding a short group with spaces.
    always_comb begin
        case (held_count_reg)
            2'd0:    closed_word = {s_tdata, bpc32_pkg::PAD_BYTE, bpc32_pkg::PAD_BYTE,
                                    bpc32_pkg::PAD_BYTE};
            2'd1:    closed_word = {held_bytes_reg[7:0], s_tdata, bpc32_pkg::PAD_BYTE,
                                    bpc32_pkg::PAD_BYTE};
            2'd2:    closed_word = {held_bytes_reg[15:0], s_tdata, bpc32_pkg::PAD_BYTE};
            default: closed_word = {held_bytes_reg, s_tdata};
        endcase
    end

    // Gather bytes until a group closes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_bytes_reg <= '0;
            held_count_reg <= '0;
        end else if (grp_close) begin
            held_bytes_reg <= '0;
            held_count_reg <= '0;
        end else if (in_beat) begin
            held_bytes_reg <= {held_bytes_reg[15:0], s_tdata};
            held_count_reg <= held_count_reg + 2'd1;
        end
    end

    // Group register between gathering and the serialiser.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_valid_reg <= 1'b0;
        end else if (grp_close) begin
            grp_valid_reg <= 1'b1;
        end else if (load) begin
            grp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (grp_close) begin
            grp_word_reg <= closed_word;
            grp_func_reg <= s_tuser;
        end
    end

    // Permutation of the waiting group.
    always_comb begin
        if (grp_func_reg == bpc32_pkg::FUNC_DECRYPT) begin
            perm_word = bpc32_pkg::decrypt_word(grp_word_reg, key_ent);
        end else begin
            perm_word = bpc32_pkg::encrypt_word(grp_word_reg, key_ent);
        end
    end

    // Output serialiser: most significant byte first.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
            out_idx_reg   <= '0;
        end else if (out_beat) begin
            out_idx_reg <= out_idx_reg + 2'd1;
            if (out_idx_reg == 2'd3) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_word_reg <= perm_word;
        end else if (out_beat) begin
            out_word_reg <= {out_word_reg[23:0], 8'h00};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg[31:24];
    assign m_tlast  = (out_idx_reg == 2'd3);

    // A stalled input always means a closed group is waiting.
    a_stall_has_group: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> grp_valid_reg)
        else $error("input stalled without a waiting group");

    // Closing a group leaves the gathering state empty.
    a_close_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        grp_close |=> (held_count_reg == 2'd0))
        else $error("gathering state not cleared after group close");

    // A loaded group starts at its first byte with output valid.
    a_load_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (m_tvalid && (out_idx_reg == 2'd0)))
        else $error("serialiser load did not start a new group");

    // The serialiser only empties after its fourth beat.
    a_empty_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !load && !(out_beat && m_tlast)) |=> out_valid_reg)
        else $error("serialiser emptied before the last beat");

endmodule

`default_nettype wire
